// ----- sv/sobel_edge_magnitude_macros.svh -----
// Assertion macros for the edge magnitude RTL.
// Included by the top level, which carries the concurrent checks; needs nothing else.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define SBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset
`define SBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/sbm_pkg.sv -----
// Package for the Sobel edge magnitude block: constants, register codes, types.
// No dependencies; used by the column cell, gradient and top level, and by the testbench.
`default_nettype none

package sbm_pkg;

   // Field widths
   localparam int PIXEL_BITS     = 8;
   localparam int COORD_BITS     = 12;
   localparam int CFG_FIELD_BITS = 13;

   // Gray conversion weights, sum is taken >> 8
   localparam logic [7:0] GRAY_R_WEIGHT = 8'd77;
   localparam logic [7:0] GRAY_G_WEIGHT = 8'd150;
   localparam logic [7:0] GRAY_B_WEIGHT = 8'd29;

   // Saturation limit of the magnitude
   localparam logic [PIXEL_BITS-1:0] MAG_MAX = 8'd255;

   // Frame geometry
   localparam int DEFAULT_MAX_WIDTH  = 4096;
   localparam int HEIGHT_LIMIT       = 4096;
   localparam int MIN_FRAME_SIZE     = 3;
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   // Register codes (word index on the configuration port)
   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One column of the 3x3 window
   typedef struct packed {
      logic [PIXEL_BITS-1:0] bot;
      logic [PIXEL_BITS-1:0] mid;
      logic [PIXEL_BITS-1:0] top;
   } column_type;

endpackage

`default_nettype wire

// ----- sv/sbm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the two gray line stores of the block.
`default_nettype none

module sbm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/sbm_column_cell.sv -----
// One window cell: holds a gray column (top, mid, bottom) and hands it on.
// Depends on sbm_pkg for column_type.
`default_nettype none

module sbm_column_cell
   import sbm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       shift_en,
   input  wire column_type load_column,
   output column_type      held_column
);

   column_type col_ff;
   column_type col_in;

   // Take the neighbor's column whenever the window moves
   always_comb begin
      col_in = col_ff;
      if (shift_en) begin
         col_in = load_column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign held_column = col_ff;

endmodule

`default_nettype wire

// ----- sv/sbm_gradient.sv -----
// Sobel gradients of a 3x3 window and the saturated |Gx| + |Gy|.
// Depends on sbm_pkg for column_type and the saturation limit.
`default_nettype none

module sbm_gradient
   import sbm_pkg::*;
(
   input  wire column_type             left_column,
   input  wire column_type             center_column,
   input  wire column_type             right_column,
   output logic [PIXEL_BITS-1:0]       magnitude
);

   logic [PIXEL_BITS+1:0] right_sum;
   logic [PIXEL_BITS+1:0] left_sum;
   logic [PIXEL_BITS+1:0] bottom_sum;
   logic [PIXEL_BITS+1:0] top_sum;
   logic [PIXEL_BITS+1:0] abs_gx;
   logic [PIXEL_BITS+1:0] abs_gy;
   logic [PIXEL_BITS+2:0] mag_sum;

   // Weighted 1-2-1 sums of the outer columns and rows
   always_comb begin
      right_sum  = {2'b00, right_column.top} + {1'b0, right_column.mid, 1'b0}
                 + {2'b00, right_column.bot};
      left_sum   = {2'b00, left_column.top} + {1'b0, left_column.mid, 1'b0}
                 + {2'b00, left_column.bot};
      bottom_sum = {2'b00, left_column.bot} + {1'b0, center_column.bot, 1'b0}
                 + {2'b00, right_column.bot};
      top_sum    = {2'b00, left_column.top} + {1'b0, center_column.top, 1'b0}
                 + {2'b00, right_column.top};
   end

   // Absolute differences, then saturating sum
   always_comb begin
      abs_gx  = (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
      abs_gy  = (bottom_sum >= top_sum) ? bottom_sum - top_sum : top_sum - bottom_sum;
      mag_sum = {1'b0, abs_gx} + {1'b0, abs_gy};
      if (mag_sum > {3'b000, MAG_MAX}) begin
         magnitude = MAG_MAX;
      end else begin
         magnitude = mag_sum[PIXEL_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- sv/sobel_edge_magnitude.sv -----
// Sobel edge magnitude, top level: gray conversion, line store, window cells.
// Depends on sbm_pkg, sbm_ram, sbm_column_cell, sbm_gradient and the macro header.
//
// Usage:
//  - req channel: one RGB pixel per item in raster order, tdata = red, green, blue.
//  - rsp channel: one item per interior pixel (row and column >= 1 and short of the
//    far border): magnitude, centre column and row; tlast marks the last of a frame.
//  - Pixels of the first two rows and columns of a frame give no result.
//  - Result path: an accepted pixel is held in the stage 1 registers, then its result
//    in the output register.
//  - Throughput: one pixel per cycle while rsp is not stalled; the window cells and the
//    line store RAM (one read and one write port) all move once per accepted pixel.
//  - Line store read data is registered, so the next pixel's read overlaps the
//    current pixel's write-back of the same RAM.
//  - Reset clears counters, window and handshake state; no clearing pass runs, the
//    block takes pixels in the cycle after reset.
//  - A stalled rsp holds its result; pixels still enter stage 1 until one with a
//    result waits there, then req_tready drops until the result is taken.
//  - Writing frame_width (0x0) or frame_height (0x4) restarts the frame position.
`default_nettype none
`include "sobel_edge_magnitude_macros.svh"

module sobel_edge_magnitude
   import sbm_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // pixel input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   // result output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // edge_magnitude [7:0], center_column [19:8],
                                         // center_row [31:20]
   output logic             rsp_tlast,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = (CW + 1 > CFG_FIELD_BITS) ? CW + 1 : CFG_FIELD_BITS;
   localparam int WIDTH_RESET_EFF =
      (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
   localparam logic [CW-1:0]         COL_LAST_RESET = CW'(WIDTH_RESET_EFF - 1);
   localparam logic [COORD_BITS-1:0] ROW_LAST_RESET = COORD_BITS'(FRAME_HEIGHT_RESET - 1);

   // ---------------- configuration registers ----------------
   logic [CFG_FIELD_BITS-1:0] frame_width_ff,  frame_width_in;
   logic [CFG_FIELD_BITS-1:0] frame_height_ff, frame_height_in;
   logic [CW-1:0]             col_last_ff,     col_last_in;
   logic [COORD_BITS-1:0]     row_last_ff,     row_last_in;
   logic                      csr_write;
   csr_index_type             csr_index;
   logic [CFG_FIELD_BITS-1:0] csr_value;
   logic [LW-1:0]             csr_value_ext;
   logic [CW-1:0]             wr_col_last;
   logic [COORD_BITS-1:0]     wr_row_last;

   assign csr_write     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index     = csr_index_type'(csr_paddr[2]);
   assign csr_value     = csr_pwdata[CFG_FIELD_BITS-1:0];
   assign csr_value_ext = LW'(csr_value);
   assign csr_pready    = 1'b1;

   // Clamp the written sizes and keep the last column and row index
   always_comb begin
      if (csr_value_ext < LW'(MIN_FRAME_SIZE)) begin
         wr_col_last = CW'(MIN_FRAME_SIZE - 1);
      end else if (csr_value_ext > LW'(MAX_WIDTH)) begin
         wr_col_last = CW'(MAX_WIDTH - 1);
      end else begin
         wr_col_last = CW'(csr_value_ext - LW'(1));
      end
      if (csr_value < CFG_FIELD_BITS'(MIN_FRAME_SIZE)) begin
         wr_row_last = COORD_BITS'(MIN_FRAME_SIZE - 1);
      end else if (csr_value > CFG_FIELD_BITS'(HEIGHT_LIMIT)) begin
         wr_row_last = COORD_BITS'(HEIGHT_LIMIT - 1);
      end else begin
         wr_row_last = COORD_BITS'(csr_value - CFG_FIELD_BITS'(1));
      end
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_last_in     = col_last_ff;
      row_last_in     = row_last_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               frame_width_in = csr_value;
               col_last_in    = wr_col_last;
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = csr_value;
               row_last_in     = wr_row_last;
            end
            default: begin
               frame_width_in = frame_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_FIELD_BITS'(FRAME_WIDTH_RESET);
         frame_height_ff <= CFG_FIELD_BITS'(FRAME_HEIGHT_RESET);
         col_last_ff     <= COL_LAST_RESET;
         row_last_ff     <= ROW_LAST_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_last_ff     <= col_last_in;
         row_last_ff     <= row_last_in;
      end
   end

   // Read back
   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:  csr_prdata = 32'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = 32'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- handshake control ----------------
   logic req_accept;
   logic s1_valid_ff, s1_valid_in;
   logic s1_emit_ff,  s1_emit_in;
   logic s1_last_ff,  s1_last_in;
   logic s1_advance;
   logic out_free;
   logic rsp_valid_ff, rsp_valid_in;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   // ---------------- stage 0: gray and position ----------------
   logic [CW-1:0]           col_cnt_ff, col_cnt_in;
   logic [COORD_BITS-1:0]   row_cnt_ff, row_cnt_in;
   logic [15:0]             gray_sum;
   logic [PIXEL_BITS-1:0]   gray;
   logic                    at_col_last;
   logic                    at_row_last;

   always_comb begin
      gray_sum = {8'h00, req_tdata[7:0]}   * {8'h00, GRAY_R_WEIGHT}
               + {8'h00, req_tdata[15:8]}  * {8'h00, GRAY_G_WEIGHT}
               + {8'h00, req_tdata[23:16]} * {8'h00, GRAY_B_WEIGHT};
      gray     = gray_sum[15:8];
   end

   assign at_col_last = (col_cnt_ff == col_last_ff);
   assign at_row_last = (row_cnt_ff == row_last_ff);

   // Raster position of the next pixel; a register write restarts the frame
   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (csr_write) begin
         col_cnt_in = '0;
         row_cnt_in = '0;
      end else if (req_accept) begin
         if (at_col_last) begin
            col_cnt_in = '0;
            row_cnt_in = at_row_last ? '0 : row_cnt_ff + COORD_BITS'(1);
         end else begin
            col_cnt_in = col_cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // ---------------- stage 1 registers ----------------
   logic [PIXEL_BITS-1:0]   s1_gray_ff, s1_gray_in;
   logic [CW-1:0]           s1_col_ff,  s1_col_in;
   logic [COORD_BITS-1:0]   s1_row_ff,  s1_row_in;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_emit_in  = s1_emit_ff;
      s1_last_in  = s1_last_ff;
      s1_gray_in  = s1_gray_ff;
      s1_col_in   = s1_col_ff;
      s1_row_in   = s1_row_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_emit_in  = (row_cnt_ff >= COORD_BITS'(2)) && (col_cnt_ff >= CW'(2));
         s1_last_in  = at_col_last && at_row_last;
         s1_gray_in  = gray;
         s1_col_in   = col_cnt_ff;
         s1_row_in   = row_cnt_ff;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_emit_ff  <= s1_emit_in;
         s1_last_ff  <= s1_last_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_gray_ff <= s1_gray_in;
      s1_col_ff  <= s1_col_in;
      s1_row_ff  <= s1_row_in;
   end

   // ---------------- line store: {newer row, older row} ----------------
   logic [2*PIXEL_BITS-1:0] line_rd_data;
   logic [2*PIXEL_BITS-1:0] line_wr_data;

   // Older row gets the old newer-row value, newer row gets this gray
   assign line_wr_data = {s1_gray_ff, line_rd_data[2*PIXEL_BITS-1:PIXEL_BITS]};

   sbm_ram #(
      .WIDTH (2 * PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr_data),
      .rd_en   (req_accept),
      .rd_addr (col_cnt_ff),
      .rd_data (line_rd_data)
   );

   // ---------------- window cells ----------------
   column_type incoming_column;
   column_type center_col;
   column_type left_col;
   logic [PIXEL_BITS-1:0] magnitude;

   always_comb begin
      incoming_column.top = line_rd_data[PIXEL_BITS-1:0];
      incoming_column.mid = line_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
      incoming_column.bot = s1_gray_ff;
   end

   sbm_column_cell u_cell_center (
      .clock       (clock),
      .reset       (reset),
      .shift_en    (s1_advance),
      .load_column (incoming_column),
      .held_column (center_col)
   );

   sbm_column_cell u_cell_left (
      .clock       (clock),
      .reset       (reset),
      .shift_en    (s1_advance),
      .load_column (center_col),
      .held_column (left_col)
   );

   sbm_gradient u_gradient (
      .left_column   (left_col),
      .center_column (center_col),
      .right_column  (incoming_column),
      .magnitude     (magnitude)
   );

   // ---------------- output register ----------------
   logic [PIXEL_BITS-1:0]   rsp_mag_ff,  rsp_mag_in;
   logic [COORD_BITS-1:0]   rsp_col_ff,  rsp_col_in;
   logic [COORD_BITS-1:0]   rsp_row_ff,  rsp_row_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [CW-1:0]           s1_col_dec;
   logic                    rsp_load;

   assign s1_col_dec = s1_col_ff - CW'(1);
   assign rsp_load   = s1_advance && s1_emit_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_mag_in   = magnitude;
         rsp_col_in   = COORD_BITS'(s1_col_dec);
         rsp_row_in   = s1_row_ff - COORD_BITS'(1);
         rsp_last_in  = s1_last_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mag_ff  <= rsp_mag_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_row_ff, rsp_col_ff, rsp_mag_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- checks ----------------
   `SBM_ASSERT_NOW(col_in_frame, clock, reset, 1'b1, col_cnt_ff <= col_last_ff,
      "column counter past the last column")
   `SBM_ASSERT_NOW(row_in_frame, clock, reset, 1'b1, row_cnt_ff <= row_last_ff,
      "row counter past the last row")
   `SBM_ASSERT_NOW(last_on_final_row, clock, reset, rsp_valid_ff && rsp_last_ff,
      rsp_row_ff == row_last_ff - COORD_BITS'(1), "frame end flagged off the final row")
   `SBM_ASSERT_NEXT(col_wraps, clock, reset, req_accept && at_col_last && !csr_write,
      col_cnt_ff == '0, "column counter failed to wrap at row end")

endmodule

`default_nettype wire

// ----- tb/sobel_edge_magnitude_tb.sv -----
// Testbench for sobel_edge_magnitude: RGB pixel stream in, edge magnitude items out.
// Checks every result against an in-bench predictor; needs sbm_pkg and the block RTL.
`timescale 1ns / 100ps

module sobel_edge_magnitude_tb;
   import sbm_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned EXTREME_RUN   = 64;

   localparam logic [23:0] BLACK_PIXEL = 24'h000000;
   localparam logic [23:0] WHITE_PIXEL = 24'hFFFFFF;
   localparam logic [23:0] RED_PIXEL   = 24'h0000FF;
   localparam logic [23:0] GREEN_PIXEL = 24'h00FF00;
   localparam logic [23:0] BLUE_PIXEL  = 24'hFF0000;

   typedef enum {PIX_NOISE, PIX_FLAT, PIX_RAMP, PIX_PRIMARY} pixel_style_type;

   typedef struct packed {
      logic [7:0]  magnitude;
      logic [11:0] column;
      logic [11:0] row;
      logic        last;
   } edge_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // red [7:0], green [15:8], blue [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // edge_magnitude [7:0], center_column [19:8], center_row [31:20]
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [7:0]  upper_line [DEFAULT_MAX_WIDTH];
   logic [7:0]  middle_line [DEFAULT_MAX_WIDTH];
   int          window_px [6];
   int unsigned next_col;
   int unsigned next_row;
   logic [12:0] width_reg;
   logic [12:0] height_reg;

   edge_result_type expected_edges [$];
   int unsigned  error_count;
   int unsigned  cycle_count;
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;

   sobel_edge_magnitude uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // effective frame size: register clamped to the supported range
   function automatic int unsigned clamp_dim(input logic [12:0] value, input int unsigned hi);
      if (value < MIN_FRAME_SIZE) return MIN_FRAME_SIZE;
      if (value > hi) return hi;
      return value;
   endfunction

   // gray conversion, window shift and Sobel magnitude for one accepted pixel
   function automatic void predict_edge(input logic [23:0] pixel);
      int unsigned w;
      int unsigned h;
      int gray;
      int top;
      int mid;
      int gx;
      int gy;
      int mag;
      edge_result_type res;
      w = clamp_dim(width_reg, DEFAULT_MAX_WIDTH);
      h = clamp_dim(height_reg, HEIGHT_LIMIT);
      gray = (int'(GRAY_R_WEIGHT) * int'(pixel[7:0]) + int'(GRAY_G_WEIGHT) * int'(pixel[15:8])
              + int'(GRAY_B_WEIGHT) * int'(pixel[23:16])) >> 8;
      top = upper_line[next_col];
      mid = middle_line[next_col];
      // full window once two rows and two columns are behind us
      if (next_row >= 2 && next_col >= 2) begin
         gx = (top + 2 * mid + gray) - (window_px[0] + 2 * window_px[1] + window_px[2]);
         gy = (window_px[2] + 2 * window_px[5] + gray) - (window_px[0] + 2 * window_px[3] + top);
         mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
         if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
         res.magnitude = mag[7:0];
         res.column    = 12'(next_col - 1);
         res.row       = 12'(next_row - 1);
         res.last      = (next_row == h - 1) && (next_col == w - 1);
         expected_edges.push_back(res);
      end
      window_px[0] = window_px[3];
      window_px[1] = window_px[4];
      window_px[2] = window_px[5];
      window_px[3] = top;
      window_px[4] = mid;
      window_px[5] = gray;
      upper_line[next_col]  = mid[7:0];
      middle_line[next_col] = gray[7:0];
      // raster position, wraps at end of frame
      if (next_col + 1 >= w) begin
         next_col = 0;
         next_row = (next_row + 1 >= h) ? 0 : next_row + 1;
      end else begin
         next_col = next_col + 1;
      end
   endfunction

   function automatic logic [23:0] make_pixel(input pixel_style_type style,
                                              input int unsigned base,
                                              input int unsigned sx, input int unsigned sy,
                                              input int unsigned x, input int unsigned y);
      int unsigned v;
      case (style)
         PIX_NOISE: begin
            return 24'($urandom);
         end
         PIX_FLAT: begin
            v = base + $urandom_range(7);
            if (v > 255) v = 255;
         end
         PIX_RAMP: begin
            v = (base + x * sx + y * sy) % 256;
         end
         default: begin
            return {{8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
                    {8{$urandom_range(1) == 1}}};
         end
      endcase
      return {v[7:0], v[7:0], v[7:0]};
   endfunction

   // one pixel item; entered and left at a falling edge
   task automatic send_pixel(input logic [23:0] pixel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      do @(posedge clock); while (!req_tready);
      predict_edge(pixel);
      @(negedge clock);
   endtask

   // hold off the sender until every expected item has come, then let the block settle
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_edges.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // a write restarts the frame position
      if (idx == REG_FRAME_WIDTH) width_reg = value[12:0];
      else height_reg = value[12:0];
      next_col = 0;
      next_row = 0;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_read(input csr_index_type idx, output logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // reset values, then write/read back with junk above the 13 register bits
   task automatic test_register_access();
      logic [31:0] value;
      logic [31:0] junk;
      logic [12:0] pattern;
      csr_index_type idx;
      csr_read(REG_FRAME_WIDTH, value);
      if (value !== 32'(FRAME_WIDTH_RESET)) begin
         $error("frame_width mismatch: expected %0d, actual %0d", FRAME_WIDTH_RESET, value);
         error_count++;
      end
      csr_read(REG_FRAME_HEIGHT, value);
      if (value !== 32'(FRAME_HEIGHT_RESET)) begin
         $error("frame_height mismatch: expected %0d, actual %0d", FRAME_HEIGHT_RESET, value);
         error_count++;
      end
      for (int i = 0; i < 4; i++) begin
         idx     = csr_index_type'(i % 2);
         pattern = (i < 2) ? 13'h1AAA : 13'h0555;
         junk    = $urandom;
         csr_write(idx, {junk[31:13], pattern});
         csr_read(idx, value);
         if (value !== 32'(pattern)) begin
            $error("%s mismatch: expected %0d, actual %0d",
                   idx == REG_FRAME_WIDTH ? "frame_width" : "frame_height", pattern, value);
            error_count++;
         end
      end
   endtask

   // 3x3 frames: saturating vertical step, unsaturated primaries by row, flat white
   task automatic test_edge_patterns();
      logic [23:0] pixel;
      wait_drain();
      csr_write(REG_FRAME_WIDTH, 3);
      csr_write(REG_FRAME_HEIGHT, 3);
      for (int f = 0; f < 3; f++) begin
         for (int k = 0; k < 9; k++) begin
            if (f == 0) pixel = (k % 3 == 0) ? WHITE_PIXEL : BLACK_PIXEL;
            else if (f == 1) pixel = (k < 3) ? RED_PIXEL : (k < 6) ? GREEN_PIXEL : BLUE_PIXEL;
            else pixel = WHITE_PIXEL;
            send_pixel(pixel);
         end
      end
   endtask

   // sizes below the minimum clamp to three
   task automatic test_size_floor();
      for (int i = 0; i < 2; i++) begin
         wait_drain();
         csr_write(REG_FRAME_WIDTH, i == 0 ? 0 : 2);
         csr_write(REG_FRAME_HEIGHT, i == 0 ? 2 : 1);
         for (int k = 0; k < 9; k++) send_pixel(make_pixel(PIX_NOISE, 0, 0, 0, 0, 0));
      end
   endtask

   // random geometries, whole and cut-short frames, occasional drain mid-frame
   task automatic test_random_frames(input int unsigned pixel_budget);
      int unsigned sent;
      int unsigned w_val;
      int unsigned h_val;
      int unsigned ew;
      int unsigned eh;
      int unsigned total;
      int unsigned pause_at;
      int unsigned base;
      int unsigned sx;
      int unsigned sy;
      pixel_style_type style;
      sent = 0;
      while (sent < pixel_budget) begin
         case ($urandom_range(9))
            0: w_val = $urandom_range(2);
            1: w_val = $urandom_range(40, 17);
            default: w_val = $urandom_range(16, 3);
         endcase
         h_val = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
         ew = clamp_dim(w_val, DEFAULT_MAX_WIDTH);
         eh = clamp_dim(h_val, HEIGHT_LIMIT);
         wait_drain();
         csr_write(REG_FRAME_WIDTH, w_val);
         csr_write(REG_FRAME_HEIGHT, h_val);
         total = $urandom_range(3, 1) * ew * eh;
         if ($urandom_range(4) == 0) total = $urandom_range(total - 1, 1);
         pause_at = ($urandom_range(3) == 0) ? $urandom_range(total - 1) : total;
         style = pixel_style_type'($urandom_range(3));
         base  = $urandom_range(255);
         sx    = $urandom_range(20);
         sy    = $urandom_range(20);
         for (int unsigned k = 0; k < total; k++) begin
            if (k == pause_at) wait_drain();
            send_pixel(make_pixel(style, base, sx, sy, k % ew, (k / ew) % eh));
         end
         sent += total;
      end
   endtask

   // short runs at the widest frame (register above range) and the tallest frame
   task automatic test_frame_extremes();
      int unsigned widths [2];
      int unsigned heights [2];
      int unsigned ew;
      widths  = '{8191, 3};
      heights = '{0, 4096};
      for (int i = 0; i < 2; i++) begin
         wait_drain();
         csr_write(REG_FRAME_WIDTH, widths[i]);
         csr_write(REG_FRAME_HEIGHT, heights[i]);
         ew = clamp_dim(widths[i], DEFAULT_MAX_WIDTH);
         for (int unsigned k = 0; k < EXTREME_RUN; k++)
            send_pixel(make_pixel(i == 0 ? PIX_RAMP : PIX_FLAT, 100, 1, 3, k % ew, k / ew));
      end
   endtask

   // receiver back-pressure
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // compare each result item with the oldest expectation
   always @(posedge clock) begin
      edge_result_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_edges.size() == 0) begin
            $error("result with no expectation: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            exp_item = expected_edges.pop_front();
            if (rsp_tdata[7:0] !== exp_item.magnitude) begin
               $error("edge_magnitude mismatch: expected %0d, actual %0d",
                      exp_item.magnitude, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[19:8] !== exp_item.column) begin
               $error("center_column mismatch: expected %0d, actual %0d",
                      exp_item.column, rsp_tdata[19:8]);
               error_count++;
            end
            if (rsp_tdata[31:20] !== exp_item.row) begin
               $error("center_row mismatch: expected %0d, actual %0d",
                      exp_item.row, rsp_tdata[31:20]);
               error_count++;
            end
            if (rsp_tlast !== exp_item.last) begin
               $error("last_of_frame mismatch: expected %0d, actual %0d",
                      exp_item.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      error_count   = 0;
      cycle_count   = 0;
      send_idle_pct = 38;
      recv_idle_pct = 47;
      next_col      = 0;
      next_row      = 0;
      width_reg     = 13'(FRAME_WIDTH_RESET);
      height_reg    = 13'(FRAME_HEIGHT_RESET);
      foreach (window_px[i]) window_px[i] = 0;
      foreach (upper_line[i]) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles more lightly than the receiver
      test_register_access();
      test_edge_patterns();
      test_size_floor();
      test_random_frames(380);

      // roles swapped
      send_idle_pct = 47;
      recv_idle_pct = 38;
      test_random_frames(380);

      // full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(360);
      test_frame_extremes();

      wait_drain();
      if (error_count == 0 && expected_edges.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sbm_pkg.sv
sv/sbm_ram.sv
sv/sbm_column_cell.sv
sv/sbm_gradient.sv
sv/sobel_edge_magnitude.sv
tb/sobel_edge_magnitude_tb.sv
